/* src/arpc_pkg.sv */
`default_nettype none

package arpc_pkg;

	// Table size default
	localparam int unsigned ENTRIES_DEFAULT = 16;

	// Field widths
	localparam int unsigned IP_W   = 32;
	localparam int unsigned MAC_W  = 48;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned OP_W   = 2;
	localparam int unsigned CFG_W  = 48;

	// Item operation codes
	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
	localparam logic [OP_W-1:0] OP_RX      = 2'd1;
	localparam logic [OP_W-1:0] OP_REQUEST = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_MISS    = 3'd0;
	localparam logic [STAT_W-1:0] STAT_HIT     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_DROP    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_CACHED  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_REPLY   = 3'd4;
	localparam logic [STAT_W-1:0] STAT_REQUEST = 3'd5;

	// Configuration register indexes
	localparam logic CFG_OWN_IP  = 1'b0;
	localparam logic CFG_OWN_MAC = 1'b1;

	// ARP header checks
	localparam logic [15:0] ARP_MIN_LEN   = 16'd28;
	localparam logic [15:0] ARP_HTYPE_ETH = 16'd1;
	localparam logic [15:0] ARP_PTYPE_IP4 = 16'h0800;
	localparam logic [7:0]  ARP_HLEN      = 8'd6;
	localparam logic [7:0]  ARP_PLEN      = 8'd4;
	localparam logic [15:0] ARP_OPER_REQ  = 16'd1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* src/arpc_ram.sv */
`default_nettype none

module arpc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/arp_cache_and_responder_top.sv */
// Flow: a lookup, or a received packet that passes the header checks, scans the table
// after the input transfer (one table read per cycle over every slot), then an update state
// writes the entry back for a received packet and forms the result; a dropped packet, a send
// request or an unused op goes straight to the result. One item at a time: input reopens
// the cycle after the result is registered into the output, which waits while it is stalled.
// Reset: asynchronous, active low; all table entries invalid, own_ip cleared, no result held.
`default_nettype none

module arp_cache_and_responder_top #(
	parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [arpc_pkg::CFG_W-1:0]    cfg_data,
	// Input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [arpc_pkg::OP_W-1:0]     op,
	input  wire logic [arpc_pkg::IP_W-1:0]     tgt_ip,
	input  wire logic [15:0]                   frame_length,
	input  wire logic [15:0]                   hw_type,
	input  wire logic [15:0]                   proto_type,
	input  wire logic [7:0]                    hw_len,
	input  wire logic [7:0]                    proto_len,
	input  wire logic [15:0]                   operation,
	input  wire logic [arpc_pkg::MAC_W-1:0]    sender_mac,
	input  wire logic [arpc_pkg::IP_W-1:0]     sender_ip,
	// Output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [arpc_pkg::STAT_W-1:0]   status,
	output logic      [arpc_pkg::MAC_W-1:0]    mac_value,
	output logic      [arpc_pkg::IP_W-1:0]     ip_value
);

	localparam int unsigned AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W  = AW + 1;
	localparam int unsigned ENT_W  = arpc_pkg::IP_W + arpc_pkg::MAC_W;
	localparam logic [AW-1:0]    LAST_IDX = AW'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

	arpc_pkg::state_t state_q, state_d;

	logic                          in_xfer;
	logic                          pkt_ok;
	logic                          ram_re, ram_we, load_out;
	logic [ENT_W-1:0]              ram_rdata;
	logic [arpc_pkg::IP_W-1:0]     ram_ip;
	logic [arpc_pkg::MAC_W-1:0]    ram_mac;
	logic [AW-1:0]                 wr_idx;
	logic                          ent_match, ent_cand, scan_last;

	logic [ENTRIES-1:0]            valid_q;
	logic [CNT_W-1:0]              rd_cnt_q;
	logic                          rd_s1;
	logic [AW-1:0]                 idx_s1;
	logic                          found_q;
	logic [AW-1:0]                 found_idx_q;
	logic [arpc_pkg::MAC_W-1:0]    hit_mac_q;
	logic                          lookup_q, reply_q;
	logic [arpc_pkg::IP_W-1:0]     key_q;
	logic [arpc_pkg::MAC_W-1:0]    smac_q;
	logic [arpc_pkg::STAT_W-1:0]   res_status_q;
	logic [arpc_pkg::MAC_W-1:0]    res_mac_q;
	logic [arpc_pkg::IP_W-1:0]     res_ip_q;
	logic [arpc_pkg::IP_W-1:0]     own_ip_q;
	logic                          out_valid_q;
	logic [arpc_pkg::STAT_W-1:0]   out_status_q;
	logic [arpc_pkg::MAC_W-1:0]    out_mac_q;
	logic [arpc_pkg::IP_W-1:0]     out_ip_q;

	// Header checks on the incoming packet
	assign pkt_ok = (frame_length >= arpc_pkg::ARP_MIN_LEN)
		&& (hw_type == arpc_pkg::ARP_HTYPE_ETH)
		&& (proto_type == arpc_pkg::ARP_PTYPE_IP4)
		&& (hw_len == arpc_pkg::ARP_HLEN)
		&& (proto_len == arpc_pkg::ARP_PLEN);

	assign in_xfer = in_valid && !in_stall;

	// Table: {ip, mac} per slot; valid bits kept in flops
	arpc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx),
		.wdata({key_q, smac_q}),
		.re   (ram_re),
		.raddr(rd_cnt_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign ram_ip  = ram_rdata[ENT_W-1 -: arpc_pkg::IP_W];
	assign ram_mac = ram_rdata[arpc_pkg::MAC_W-1:0];

	// Slot compare on returned read data
	assign ent_match = valid_q[idx_s1] && (ram_ip == key_q);
	assign ent_cand  = lookup_q ? ent_match : (!valid_q[idx_s1] || (ram_ip == key_q));
	assign scan_last = rd_s1 && (idx_s1 == LAST_IDX);

	// Insert slot: first free or same-IP slot, else slot 0
	assign wr_idx = found_q ? found_idx_q : '0;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			arpc_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (op == arpc_pkg::OP_LOOKUP || (op == arpc_pkg::OP_RX && pkt_ok)) begin
						state_d = arpc_pkg::ST_SCAN;
					end else begin
						state_d = arpc_pkg::ST_DONE;
					end
				end
			end
			arpc_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = arpc_pkg::ST_UPDATE;
				end
			end
			arpc_pkg::ST_UPDATE: begin
				state_d = arpc_pkg::ST_DONE;
			end
			arpc_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = arpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = arpc_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		in_stall = 1'b1;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			arpc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			arpc_pkg::ST_SCAN: begin
				ram_re = (rd_cnt_q != CNT_END);
			end
			arpc_pkg::ST_UPDATE: begin
				ram_we = !lookup_q;
			end
			arpc_pkg::ST_DONE: begin
				load_out = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= arpc_pkg::ST_IDLE;
			valid_q     <= '0;
			rd_cnt_q    <= '0;
			rd_s1       <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			own_ip_q    <= '0;
		end else begin
			state_q <= state_d;
			rd_s1   <= ram_re;
			if (in_xfer) begin
				rd_cnt_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (ram_re) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (rd_s1 && ent_cand) begin
					found_q <= 1'b1;
				end
			end
			if (ram_we) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// own_mac only feeds frame building outside this block
			if (cfg_we && cfg_index == arpc_pkg::CFG_OWN_IP) begin
				own_ip_q <= cfg_data[arpc_pkg::IP_W-1:0];
			end
		end
	end

	// Item, scan and result payload
	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[AW-1:0];
		if (rd_s1 && ent_cand && !found_q) begin
			found_idx_q <= idx_s1;
			hit_mac_q   <= ram_mac;
		end
		if (in_xfer) begin
			lookup_q <= (op == arpc_pkg::OP_LOOKUP);
			key_q    <= (op == arpc_pkg::OP_LOOKUP) ? tgt_ip : sender_ip;
			smac_q   <= sender_mac;
			reply_q  <= (tgt_ip == own_ip_q) && (operation == arpc_pkg::ARP_OPER_REQ);
			res_mac_q <= '0;
			if (op == arpc_pkg::OP_REQUEST) begin
				res_status_q <= arpc_pkg::STAT_REQUEST;
				res_ip_q     <= tgt_ip;
			end else begin
				res_status_q <= arpc_pkg::STAT_DROP;
				res_ip_q     <= '0;
			end
		end
		if (state_q == arpc_pkg::ST_UPDATE) begin
			if (lookup_q) begin
				res_status_q <= found_q ? arpc_pkg::STAT_HIT : arpc_pkg::STAT_MISS;
				res_mac_q    <= found_q ? hit_mac_q : '0;
				res_ip_q     <= '0;
			end else begin
				res_status_q <= reply_q ? arpc_pkg::STAT_REPLY : arpc_pkg::STAT_CACHED;
				res_mac_q    <= reply_q ? smac_q : '0;
				res_ip_q     <= reply_q ? key_q : '0;
			end
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_mac_q    <= res_mac_q;
			out_ip_q     <= res_ip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign mac_value = out_mac_q;
	assign ip_value  = out_ip_q;

`ifndef SYNTHESIS
	// A transfer always starts work on the item
	a_xfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != arpc_pkg::ST_IDLE))
		else $error("item transfer did not leave idle");

	// Table writes only at the end of a packet scan
	a_we_update: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == arpc_pkg::ST_UPDATE && !lookup_q))
		else $error("table write outside update");

	// Entries are never invalidated once filled
	a_valid_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(valid_q) >= $countones($past(valid_q))))
		else $error("valid entry lost");

	// No read is issued past the last slot
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (rd_cnt_q < CNT_END))
		else $error("table read beyond depth");
`endif

endmodule

`default_nettype wire
